// ===== rtl/neighbour_id_dedup_table_top_macros.svh =====
// assertion macros for the neighbour id dedup table
// no dependencies; included by the files that carry assertions
`ifndef NEIGHBOUR_ID_DEDUP_TABLE_TOP_MACROS_SVH
`define NEIGHBOUR_ID_DEDUP_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define NDT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NDT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define NDT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/ndt_pkg.sv =====
// shared types and constants for the neighbour id dedup table
// no dependencies
package ndt_pkg;

    localparam int ID_W        = 16;
    localparam int BATCH_W     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int N_W         = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_ID     = 2'd1,
        KIND_NONE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_SEEN  = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OBS_RD,
        S_OBS_CMP,
        S_OBS_END,
        S_DR_SCAN,
        S_DR_GOT,
        S_DR_END
    } state_t;

    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [ID_W-1:0]    id;
        logic [BATCH_W-1:0] batch;
        logic               last;
    } res_word_t;

endpackage

// ===== rtl/ndt_if.sv =====
// valid/ready channel interfaces for request and result words
// no dependencies
interface ndt_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] neighbour_id;

    modport source (output valid, output req_type, output neighbour_id, input ready);
    modport sink (input valid, input req_type, input neighbour_id, output ready);
endinterface

interface ndt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  observe_status;
    logic [15:0] reported_id;
    logic [15:0] batch_number;
    logic        last;

    modport source (
        output valid, output result_kind, output observe_status,
        output reported_id, output batch_number, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input observe_status,
        input reported_id, input batch_number, input last, output ready
    );
endinterface

// ===== rtl/ndt_out_stage.sv =====
// output register holding one result word toward the result channel
// depends on ndt_pkg, ndt_if and the assertion macro header
`include "neighbour_id_dedup_table_top_macros.svh"

module ndt_out_stage
    import ndt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_word_t word,
    output logic      free,
    ndt_res_if.source res
);

    logic      valid_reg;
    logic      valid_next;
    res_word_t word_reg;

    assign free = !valid_reg || res.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && !res.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

    assign res.valid          = valid_reg;
    assign res.result_kind    = word_reg.kind;
    assign res.observe_status = word_reg.status;
    assign res.reported_id    = word_reg.id;
    assign res.batch_number   = word_reg.batch;
    assign res.last           = word_reg.last;

    `NDT_ASSERT_NR(a_rst_clear, clk, !rst_n |=> !valid_reg, "output valid not cleared by reset")
    `NDT_ASSERT(a_load_free, clk, rst_n, load |-> free, "word loaded over an unsent word")
    `NDT_ASSERT(a_load_shown, clk, rst_n, load |=> valid_reg, "loaded word not presented")

endmodule

// ===== rtl/neighbour_id_dedup_table_top.sv =====
// neighbour id dedup table: request channel in, result channel out
// an observe adds a new id or reports seen/full; a drain emits up to MAX_RESULTS unreported ids, or a none word
// channels: req (req_type, neighbour_id) and res (result_kind, observe_status,
// reported_id, batch_number, last), valid/ready, a word moves when both are high
// one request is handled at a time; req.ready is high only while the sequencer idles
// a single compare unit walks the table one slot per step through the registered
// read port of the id store:
//   observe: reads and compares each filled slot in turn, then gives its one result
//   drain:   scans the reported flags and reads each unreported slot, words leave as found
// the result register lets the next request be taken while a result word waits
// when a word is due and the result register is not free, the sequencer holds where it is until the register frees
// reset clears the fill count, the reported flags, the batch counter and the
// channel valids; the id store needs no clearing since only filled slots are read
// last marks the final result word of each request
`include "neighbour_id_dedup_table_top_macros.svh"

module neighbour_id_dedup_table_top
    import ndt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    ndt_req_if.sink   req,
    ndt_res_if.source res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   fill_count_reg;
    logic [CNT_W-1:0]   fill_count_next;
    logic [BATCH_W-1:0] batch_counter_reg;
    logic [BATCH_W-1:0] batch_counter_next;
    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     n_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [ID_W-1:0]    pend_id_reg;
    logic [ID_W-1:0]    pend_id_next;
    logic [ID_W-1:0]    nid_reg;
    logic [ID_W-1:0]    nid_next;
    logic               flag_reg [TABLE_DEPTH];
    logic               flag_set;

    logic [ID_W-1:0]    id_mem [TABLE_DEPTH];
    logic [ID_W-1:0]    rdata_reg;
    logic               mem_re;
    logic               mem_we;

    logic               out_load;
    logic               out_free;
    res_word_t          out_word;

    logic               hit;
    logic               at_end;
    logic               scan_done;
    logic               cur_flag;

    assign hit       = rdata_reg == nid_reg;
    assign at_end    = idx_reg == fill_count_reg;
    assign scan_done = at_end || (n_reg == N_W'(MAX_RESULTS));
    assign cur_flag  = flag_reg[idx_reg[IDX_W-1:0]];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = req.req_type ? S_DR_SCAN : S_OBS_RD;
                end
            end
            S_OBS_RD:
            begin
                state_next = at_end ? S_OBS_END : S_OBS_CMP;
            end
            S_OBS_CMP:
            begin
                if (!hit)
                begin
                    state_next = S_OBS_RD;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_OBS_END:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DR_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_DR_END;
                end
                else if (!cur_flag)
                begin
                    state_next = S_DR_GOT;
                end
            end
            S_DR_GOT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = S_DR_SCAN;
                end
            end
            S_DR_END:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req.ready          = 1'b0;
        mem_re             = 1'b0;
        mem_we             = 1'b0;
        flag_set           = 1'b0;
        out_load           = 1'b0;
        out_word           = '0;
        idx_next           = idx_reg;
        fill_count_next    = fill_count_reg;
        batch_counter_next = batch_counter_reg;
        n_next             = n_reg;
        pend_valid_next    = pend_valid_reg;
        pend_id_next       = pend_id_reg;
        nid_next           = nid_reg;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    nid_next        = req.neighbour_id;
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                end
            end
            S_OBS_RD:
            begin
                mem_re = !at_end;
            end
            S_OBS_CMP:
            begin
                if (!hit)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_word.kind   = KIND_STATUS;
                    out_word.status = ST_SEEN;
                    out_word.last   = 1'b1;
                end
            end
            S_OBS_END:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_word.kind   = KIND_STATUS;
                    out_word.last   = 1'b1;
                    if (fill_count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        out_word.status = ST_FULL;
                    end
                    else
                    begin
                        out_word.status = ST_ADDED;
                        mem_we          = 1'b1;
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                end
            end
            S_DR_SCAN:
            begin
                if (!scan_done)
                begin
                    if (!cur_flag)
                    begin
                        mem_re = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_DR_GOT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load       = 1'b1;
                        out_word.kind  = KIND_ID;
                        out_word.id    = pend_id_reg;
                        out_word.batch = batch_counter_reg;
                    end
                    if (n_reg == '0)
                    begin
                        batch_counter_next = batch_counter_reg + 1'b1;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = rdata_reg;
                    flag_set        = 1'b1;
                    n_next          = n_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                end
            end
            S_DR_END:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_word.batch = batch_counter_reg;
                    out_word.last  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_word.kind = KIND_ID;
                        out_word.id   = pend_id_reg;
                    end
                    else
                    begin
                        out_word.kind = KIND_NONE;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= '0;
            fill_count_reg    <= '0;
            batch_counter_reg <= '0;
            n_reg             <= '0;
            pend_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            fill_count_reg    <= fill_count_next;
            batch_counter_reg <= batch_counter_next;
            n_reg             <= n_next;
            pend_valid_reg    <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        nid_reg     <= nid_next;
    end

    // reported flags, one per slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                flag_reg[i] <= 1'b0;
            end
        end
        else if (flag_set)
        begin
            flag_reg[idx_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    // id store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[fill_count_reg[IDX_W-1:0]] <= nid_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= id_mem[idx_reg[IDX_W-1:0]];
        end
    end

    ndt_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .word  (out_word),
        .free  (out_free),
        .res   (res)
    );

    `NDT_ASSERT(a_fill_bound, clk, rst_n, fill_count_reg <= CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
    `NDT_ASSERT(a_fill_step, clk, rst_n, 1'b1 |=> (fill_count_reg == $past(fill_count_reg) || fill_count_reg == $past(fill_count_reg) + 1'b1), "fill count moved by more than one")
    `NDT_ASSERT(a_batch_only_drain, clk, rst_n, state_reg != S_DR_GOT |=> $stable(batch_counter_reg), "batch counter changed outside a drain")

endmodule

// ===== tb/sv/neighbour_id_dedup_table_top_tb.sv =====
// self-checking testbench for neighbour_id_dedup_table_top: directed then random requests
// depends on ndt_pkg, ndt_req_if, ndt_res_if and the top level
`timescale 1ns / 100ps

module neighbour_id_dedup_table_top_tb;
    import ndt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_WORDS = 460;
    localparam int CALM_FROM = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL = 100;

    class dedup_scoreboard;
        logic [ID_W-1:0]    stored_id[TABLE_DEPTH];
        bit                 was_reported[TABLE_DEPTH];
        int                 fill;
        logic [BATCH_W-1:0] batch_count;
        res_word_t          pending[$];
        int                 errors;

        function new();
            fill = 0;
            batch_count = '0;
            errors = 0;
            foreach (stored_id[i])
            begin
                stored_id[i] = '0;
                was_reported[i] = 1'b0;
            end
        endfunction

        function res_word_t pack_word(kind_t k, status_t s, logic [ID_W-1:0] id,
                                      logic [BATCH_W-1:0] b, logic l);
            res_word_t w;
            w.kind = k;
            w.status = s;
            w.id = id;
            w.batch = b;
            w.last = l;
            return w;
        endfunction

        function void note_request(logic rt, logic [ID_W-1:0] nid);
            int unreported;
            int n;
            unreported = 0;
            n = 0;
            if (rt == 1'b0)
            begin
                for (int i = 0; i < fill; i++)
                begin
                    if (stored_id[i] == nid)
                    begin
                        pending.push_back(pack_word(KIND_STATUS, ST_SEEN, '0, '0, 1'b1));
                        return;
                    end
                end
                if (fill >= TABLE_DEPTH)
                begin
                    pending.push_back(pack_word(KIND_STATUS, ST_FULL, '0, '0, 1'b1));
                    return;
                end
                stored_id[fill] = nid;
                was_reported[fill] = 1'b0;
                fill++;
                pending.push_back(pack_word(KIND_STATUS, ST_ADDED, '0, '0, 1'b1));
                return;
            end
            for (int i = 0; i < fill; i++)
                if (!was_reported[i])
                    unreported++;
            if (unreported == 0)
            begin
                pending.push_back(pack_word(KIND_NONE, ST_ADDED, '0, batch_count, 1'b1));
                return;
            end
            if (unreported > MAX_RESULTS)
                unreported = MAX_RESULTS;
            batch_count = batch_count + 1'b1;
            for (int i = 0; i < fill && n < unreported; i++)
            begin
                if (!was_reported[i])
                begin
                    was_reported[i] = 1'b1;
                    pending.push_back(pack_word(KIND_ID, ST_ADDED, stored_id[i], batch_count,
                                                n == unreported - 1));
                    n++;
                end
            end
        endfunction

        function void check_result(res_word_t got);
            res_word_t exp;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected: kind %0d id %0d",
                       got.kind, got.id);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
            begin
                $error("result_kind expected %0d actual %0d", exp.kind, got.kind);
                errors++;
            end
            if (got.status !== exp.status)
            begin
                $error("observe_status expected %0d actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.id !== exp.id)
            begin
                $error("reported_id expected %0d actual %0d", exp.id, got.id);
                errors++;
            end
            if (got.batch !== exp.batch)
            begin
                $error("batch_number expected %0d actual %0d", exp.batch, got.batch);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $error("last expected %0d actual %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   stall_left;
    int   cycles;

    ndt_req_if req_if ();
    ndt_res_if res_if ();

    dedup_scoreboard sb;
    logic [ID_W-1:0] id_pool[$];

    neighbour_id_dedup_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .res(res_if)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL neighbour_id_dedup_table_top");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            res_if.ready <= 1'b0;
            stall_left <= $urandom_range(1, 10) - 1;
        end
        else
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        res_word_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.kind = kind_t'(res_if.result_kind);
            got.status = status_t'(res_if.observe_status);
            got.id = res_if.reported_id;
            got.batch = res_if.batch_number;
            got.last = res_if.last;
            sb.check_result(got);
        end
    end

    task automatic send_word(logic rt, logic [ID_W-1:0] nid);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= rt;
        req_if.neighbour_id <= nid;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(rt, nid);
    endtask

    task automatic observe(logic [ID_W-1:0] nid);
        send_word(1'b0, nid);
        id_pool.push_back(nid);
    endtask

    task automatic drain();
        send_word(1'b1, ID_W'($urandom));
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            drain();
        else if (pick < 32)
            observe(ID_W'($urandom));
        else
            send_word(1'b0, id_pool[$urandom_range(0, id_pool.size() - 1)]);
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        idle_on = 1'b0;
        stall_left = 0;
        cycles = 0;
        req_if.valid = 1'b0;
        req_if.req_type = 1'b0;
        req_if.neighbour_id = '0;
        res_if.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, id zero, all-ones id, repeats and nothing new
        drain();
        observe(16'h0000);
        observe(16'h0000);
        observe(16'hffff);
        drain();
        drain();
        observe(16'hffff);
        observe(16'h5555);
        observe(16'haaaa);
        observe(16'h0000);
        drain();
        observe(16'h8001);
        drain();
        drain();

        idle_on = 1'b1;
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k >= CALM_FROM)
                idle_on = 1'b0;
            else if (k % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            random_word();
        end
        req_if.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS neighbour_id_dedup_table_top");
        else
            $display("FAIL neighbour_id_dedup_table_top");
        $finish;
    end

endmodule
